// ===== design/crc16_frame_receive_parser_core_macros.svh =====
// Assertion macros used by the checker of the frame receive parser.
// Each macro expands to one labeled concurrent assertion clocked on clk with reset rst.
`ifndef CRC16_FRAME_RECEIVE_PARSER_CORE_MACROS_SVH
`define CRC16_FRAME_RECEIVE_PARSER_CORE_MACROS_SVH

// Same-cycle implication.
`define CRCFP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CRCFP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/crcfp_pkg.sv =====
// Shared types, constants and the CRC-16/Modbus byte update of the frame receive parser.
// No dependencies; the front end, queue, back end and top level import this package.
package crcfp_pkg;

  localparam int FRAME_BUFFER_BYTES = 64;
  localparam int FRAME_OVERHEAD     = 7;
  localparam int MAX_LEN            = FRAME_BUFFER_BYTES - FRAME_OVERHEAD;
  localparam int IDX_W              = 6;
  localparam int BANK_DEPTH         = 1 << IDX_W;
  localparam int RAM_DEPTH          = 2 * BANK_DEPTH;
  localparam int RAM_AW             = $clog2(RAM_DEPTH);

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [7:0] RST_HEAD1   = 8'hA5;
  localparam logic [7:0] RST_HEAD2   = 8'h5A;
  localparam logic [7:0] RST_TRAILER = 8'hFF;

  typedef enum logic [7:0] {
    CFG_HEAD1   = 8'd0,
    CFG_HEAD2   = 8'd1,
    CFG_TRAILER = 8'd2
  } cfg_reg_t;

  typedef enum logic [7:0] {
    PH_HEAD1 = 8'b0000_0001,
    PH_HEAD2 = 8'b0000_0010,
    PH_LEN   = 8'b0000_0100,
    PH_CMD   = 8'b0000_1000,
    PH_PAY   = 8'b0001_0000,
    PH_CRCH  = 8'b0010_0000,
    PH_CRCL  = 8'b0100_0000,
    PH_TAIL  = 8'b1000_0000
  } phase_t;

  // One completed frame waiting to be drained.
  typedef struct packed {
    logic             bank;
    logic [7:0]       cmd;
    logic [IDX_W-1:0] len;
  } frame_desc_t;

  typedef struct packed {
    logic              en;
    logic [RAM_AW-1:0] addr;
    logic [7:0]        data;
  } mem_wr_t;

  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== design/crcfp_if.sv =====
// Valid/ready channel interfaces of the frame receive parser: byte in, result out, config.
// No dependencies.
interface crcfp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface crcfp_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_cmd;
  logic [5:0] payload_len;
  logic       has_payload;
  logic [7:0] data_byte;
  logic [5:0] byte_index;
  logic       last;
  modport source (output valid, output frame_cmd, output payload_len, output has_payload,
                  output data_byte, output byte_index, output last, input ready);
  modport sink (input valid, input frame_cmd, input payload_len, input has_payload,
                input data_byte, input byte_index, input last, output ready);
endinterface

interface crcfp_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] reg_index;
  logic [7:0] wdata;
  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

// ===== design/crcfp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module crcfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/crcfp_front.sv =====
// Front end: configuration registers, frame parser state machine and running CRC.
// Depends on crcfp_pkg and crcfp_if; writes payload bytes into one bank of the payload RAM.
module crcfp_front
  import crcfp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  crcfp_rx_if.sink          rx,
  crcfp_cfg_if.sink         cfg,
  input  logic              q_full,
  output logic              push,
  output frame_desc_t       push_desc,
  output mem_wr_t           mem_wr
);

  logic [7:0]       head1, head2, trailer;
  phase_t           phase, phase_next;
  logic [IDX_W-1:0] frame_len, frame_len_next;
  logic [7:0]       frame_cmd, frame_cmd_next;
  logic [IDX_W-1:0] pay_cnt, pay_cnt_next;
  logic [15:0]      crc, crc_next;
  logic [7:0]       crc_high, crc_high_next;
  logic             bank, bank_next;
  logic             accept;
  logic [7:0]       b;
  logic [15:0]      crc_upd;

  assign cfg.ready = 1'b1;
  // Both RAM banks hold undrained frames: hold off until one frees up.
  assign rx.ready  = !q_full;
  assign accept    = rx.valid && rx.ready;
  assign b         = rx.rx_byte;
  assign crc_upd   = crc_update(crc, b);

  always_ff @(posedge clk) begin
    if (rst) begin
      head1   <= RST_HEAD1;
      head2   <= RST_HEAD2;
      trailer <= RST_TRAILER;
    end else if (cfg.valid && cfg.ready) begin
      if (cfg.reg_index == CFG_HEAD1) begin
        head1 <= cfg.wdata;
      end
      if (cfg.reg_index == CFG_HEAD2) begin
        head2 <= cfg.wdata;
      end
      if (cfg.reg_index == CFG_TRAILER) begin
        trailer <= cfg.wdata;
      end
    end
  end

  always_comb begin
    logic do_clear;
    logic do_restart;
    do_clear       = 1'b0;
    do_restart     = 1'b0;
    phase_next     = phase;
    frame_len_next = frame_len;
    frame_cmd_next = frame_cmd;
    pay_cnt_next   = pay_cnt;
    crc_next       = crc;
    crc_high_next  = crc_high;
    bank_next      = bank;
    push           = 1'b0;
    mem_wr.en      = 1'b0;
    mem_wr.addr    = {bank, pay_cnt};
    mem_wr.data    = b;
    push_desc.bank = bank;
    push_desc.cmd  = frame_cmd;
    push_desc.len  = frame_len;

    if (accept) begin
      unique case (phase)
        PH_HEAD1: begin
          do_restart = (b == head1);
        end
        PH_HEAD2: begin
          if (b == head2) begin
            crc_next   = crc_upd;
            phase_next = PH_LEN;
          end else if (b == head1) begin
            do_restart = 1'b1;
          end else begin
            do_clear = 1'b1;
          end
        end
        PH_LEN: begin
          if (b > 8'(MAX_LEN)) begin
            do_clear = 1'b1;
          end else begin
            frame_len_next = b[IDX_W-1:0];
            crc_next       = crc_upd;
            phase_next     = PH_CMD;
          end
        end
        PH_CMD: begin
          frame_cmd_next = b;
          crc_next       = crc_upd;
          pay_cnt_next   = '0;
          phase_next     = (frame_len == '0) ? PH_CRCH : PH_PAY;
        end
        PH_PAY: begin
          mem_wr.en    = 1'b1;
          crc_next     = crc_upd;
          pay_cnt_next = pay_cnt + 1'b1;
          if (({1'b0, pay_cnt} + 1'b1) >= {1'b0, frame_len}) begin
            phase_next = PH_CRCH;
          end
        end
        PH_CRCH: begin
          crc_high_next = b;
          phase_next    = PH_CRCL;
        end
        PH_CRCL: begin
          if ({crc_high, b} == crc) begin
            phase_next = PH_TAIL;
          end else if (b == head1) begin
            do_restart = 1'b1;
          end else begin
            do_clear = 1'b1;
          end
        end
        PH_TAIL: begin
          if (b == trailer) begin
            push      = 1'b1;
            bank_next = !bank;
            do_clear  = 1'b1;
          end else if (b == head1) begin
            do_restart = 1'b1;
          end else begin
            do_clear = 1'b1;
          end
        end
        default: begin
          do_clear = 1'b1;
        end
      endcase
    end

    if (do_clear || do_restart) begin
      phase_next     = do_restart ? PH_HEAD2 : PH_HEAD1;
      frame_len_next = '0;
      frame_cmd_next = '0;
      pay_cnt_next   = '0;
      crc_high_next  = '0;
      // On a restart the current byte is head1 and opens the new CRC.
      crc_next       = do_restart ? crc_update(CRC_INIT, b) : CRC_INIT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HEAD1;
      frame_len <= '0;
      frame_cmd <= '0;
      pay_cnt   <= '0;
      crc       <= CRC_INIT;
      crc_high  <= '0;
      bank      <= 1'b0;
    end else begin
      phase     <= phase_next;
      frame_len <= frame_len_next;
      frame_cmd <= frame_cmd_next;
      pay_cnt   <= pay_cnt_next;
      crc       <= crc_next;
      crc_high  <= crc_high_next;
      bank      <= bank_next;
    end
  end

endmodule

// ===== design/crcfp_queue.sv =====
// Two-entry queue of completed frame descriptors between the parser and the drain.
// Depends on crcfp_pkg. An entry stays until its last result has been issued.
module crcfp_queue
  import crcfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  frame_desc_t push_desc,
  input  logic        pop,
  output logic        head_valid,
  output frame_desc_t head,
  output logic        full
);

  frame_desc_t entry [2];
  logic        wr_ptr, rd_ptr;
  logic [1:0]  count;

  assign head_valid = (count != 2'd0);
  assign full       = (count == 2'd2);
  assign head       = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== design/crcfp_back.sv =====
// Back end: walks the payload of each queued frame through the RAM and delivers results.
// Depends on crcfp_pkg and crcfp_if. RAM read stage, then the output register.
module crcfp_back
  import crcfp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  frame_desc_t       head,
  output logic              pop,
  output logic              rd_en,
  output logic [RAM_AW-1:0] rd_addr,
  input  logic [7:0]        rd_data,
  crcfp_res_if.source       res
);

  logic [IDX_W-1:0] idx;
  logic             issue, issue_last, issue_has;
  logic             s1_valid, s1_adv;
  logic [7:0]       s1_cmd;
  logic [IDX_W-1:0] s1_len, s1_idx;
  logic             s1_has, s1_last;
  logic             out_valid;

  assign s1_adv     = s1_valid && (!out_valid || res.ready);
  assign issue      = head_valid && (!s1_valid || s1_adv);
  assign issue_has  = (head.len != '0);
  assign issue_last = !issue_has || (idx == head.len - 1'b1);
  assign pop        = issue && issue_last;
  assign rd_en      = issue && issue_has;
  assign rd_addr    = {head.bank, idx};

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (issue) begin
        idx <= issue_last ? '0 : idx + 1'b1;
      end
      if (issue) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_cmd  <= head.cmd;
      s1_len  <= head.len;
      s1_idx  <= idx;
      s1_has  <= issue_has;
      s1_last <= issue_last;
    end
    if (s1_adv) begin
      res.frame_cmd   <= s1_cmd;
      res.payload_len <= s1_len;
      res.has_payload <= s1_has;
      // The RAM output holds while the read stage is stalled.
      res.data_byte   <= s1_has ? rd_data : 8'h00;
      res.byte_index  <= s1_idx;
      res.last        <= s1_last;
    end
  end

  assign res.valid = out_valid;

endmodule

// ===== design/crc16_frame_receive_parser_core.sv =====
// Receive parser for head1/head2/length/command/payload/CRC/tail frames with CRC-16/Modbus.
// It takes one byte per cycle; results leave one per cycle unless stalled, a frame of N payload
// bytes giving N results (one for an empty payload), read out of the payload RAM's single read
// port. The RAM has two banks, so one finished frame may wait while the next frame's bytes
// arrive; with both banks full the byte input stalls until the older frame's last result issues.
// Depends on crcfp_pkg, crcfp_if, crcfp_ram, crcfp_front, crcfp_queue and crcfp_back.
module crc16_frame_receive_parser_core
  import crcfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  crcfp_rx_if.sink    rx,
  crcfp_cfg_if.sink   cfg,
  crcfp_res_if.source res
);

  logic              q_full, push, pop, head_valid;
  frame_desc_t       push_desc, head;
  mem_wr_t           mem_wr;
  logic              rd_en;
  logic [RAM_AW-1:0] rd_addr;
  logic [7:0]        rd_data;

  crcfp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx),
    .cfg       (cfg),
    .q_full    (q_full),
    .push      (push),
    .push_desc (push_desc),
    .mem_wr    (mem_wr)
  );

  crcfp_ram #(
    .WIDTH (8),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_wr.en),
    .waddr (mem_wr.addr),
    .wdata (mem_wr.data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  crcfp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_desc  (push_desc),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head),
    .full       (q_full)
  );

  crcfp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .res        (res)
  );

endmodule

// ===== design/crcfp_checker.sv =====
// Port-level checks on the result channel of the frame receive parser, bound to the top level.
// Depends on crc16_frame_receive_parser_core_macros.svh.
`include "crc16_frame_receive_parser_core_macros.svh"

module crcfp_checker (
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_ready,
  input logic [7:0] frame_cmd,
  input logic [5:0] payload_len,
  input logic       has_payload,
  input logic [7:0] data_byte,
  input logic [5:0] byte_index,
  input logic       last
);

  `CRCFP_ASSERT_NEXT(a_res_hold, res_valid && !res_ready,
    res_valid && $stable(frame_cmd) && $stable(data_byte) && $stable(byte_index) && $stable(last),
    "result changed while stalled")

  `CRCFP_ASSERT_NOW(a_empty_frame, res_valid && !has_payload,
    last && data_byte == 8'h00 && byte_index == 6'd0 && payload_len == 6'd0,
    "empty-payload result malformed")

  `CRCFP_ASSERT_NOW(a_index_range, res_valid && has_payload,
    byte_index < payload_len && payload_len <= 6'd57,
    "payload index out of range")

  `CRCFP_ASSERT_NOW(a_last_mark, res_valid && has_payload,
    last == ((7'(byte_index) + 7'd1) == 7'(payload_len)),
    "last flag does not match payload position")

endmodule

bind crc16_frame_receive_parser_core crcfp_checker u_crcfp_checker (
  .clk         (clk),
  .rst         (rst),
  .res_valid   (res.valid),
  .res_ready   (res.ready),
  .frame_cmd   (res.frame_cmd),
  .payload_len (res.payload_len),
  .has_payload (res.has_payload),
  .data_byte   (res.data_byte),
  .byte_index  (res.byte_index),
  .last        (res.last)
);

// ===== bench/crc16_frame_receive_parser_core_tb.sv =====
// Self-checking bench for the CRC-16/Modbus frame receive parser: drives received bytes,
// predicts the command/payload words of every good frame and checks them as they drain.
// Depends on crcfp_pkg, the crcfp_*_if interfaces and crc16_frame_receive_parser_core.
module crc16_frame_receive_parser_core_tb
  import crcfp_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 16;
  localparam int RAND_BYTES    = 16;
  localparam int REPORT_CAP    = 100;

  typedef struct packed {
    logic [7:0] cmd;
    logic [5:0] len;
    logic       has_pay;
    logic [7:0] data;
    logic [5:0] idx;
    logic       last;
  } frame_word_t;

  // Where a stimulus byte comes from: a literal, or the CRC of the frame being sent.
  typedef enum logic [1:0] {B_LIT, B_CRC_HI, B_CRC_LO, B_CRC_HI_BAD} byte_src_t;

  typedef struct packed {
    byte_src_t   src;
    logic [7:0]  val;
    logic        typed;
    frame_word_t word;
  } stim_row_t;

  logic clk;
  logic rst;

  crcfp_rx_if  rx_ch ();
  crcfp_cfg_if cfg_ch ();
  crcfp_res_if res_ch ();

  crc16_frame_receive_parser_core dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_ch),
    .cfg (cfg_ch),
    .res (res_ch)
  );

  // Parser model state.
  logic [7:0]  head1_reg;
  logic [7:0]  head2_reg;
  logic [7:0]  trailer_reg;
  phase_t      parse_ph;
  logic [5:0]  frame_len;
  logic [7:0]  frame_cmd;
  logic [5:0]  pay_cnt;
  logic [15:0] run_crc;
  logic [7:0]  crc_hi;
  logic [7:0]  pay_buf [0:MAX_LEN-1];

  frame_word_t frame_words [$];
  frame_word_t pending_words [$];
  stim_row_t   stim_rows [$];

  int mismatches;
  int burst_left;
  int quiet_cycles;
  int stall_tick;
  int stall_mode;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = c;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ b[i];
      r  = r >> 1;
      if (fb) r = r ^ CRC_POLY;
    end
    return r;
  endfunction

  function automatic void clear_frame();
    parse_ph  = PH_HEAD1;
    frame_len = '0;
    frame_cmd = '0;
    pay_cnt   = '0;
    run_crc   = CRC_INIT;
    crc_hi    = '0;
  endfunction

  function automatic void restart_frame();
    clear_frame();
    parse_ph = PH_HEAD2;
    run_crc  = crc16_step(CRC_INIT, head1_reg);
  endfunction

  // Advances the parser by one received byte; the words a good tail releases go to frame_words.
  function automatic void parse_rx_byte(input logic [7:0] b);
    frame_words.delete();
    case (parse_ph)
      PH_HEAD1: begin
        if (b == head1_reg) restart_frame();
      end
      PH_HEAD2: begin
        if (b == head2_reg) begin
          run_crc  = crc16_step(run_crc, b);
          parse_ph = PH_LEN;
        end else if (b == head1_reg) begin
          restart_frame();
        end else begin
          clear_frame();
        end
      end
      PH_LEN: begin
        if (int'(b) > MAX_LEN) begin
          clear_frame();
        end else begin
          frame_len = b[5:0];
          run_crc   = crc16_step(run_crc, b);
          parse_ph  = PH_CMD;
        end
      end
      PH_CMD: begin
        frame_cmd = b;
        run_crc   = crc16_step(run_crc, b);
        pay_cnt   = '0;
        parse_ph  = (frame_len == 0) ? PH_CRCH : PH_PAY;
      end
      PH_PAY: begin
        pay_buf[pay_cnt] = b;
        run_crc          = crc16_step(run_crc, b);
        pay_cnt          = pay_cnt + 6'd1;
        if (pay_cnt >= frame_len) parse_ph = PH_CRCH;
      end
      PH_CRCH: begin
        crc_hi   = b;
        parse_ph = PH_CRCL;
      end
      PH_CRCL: begin
        if ({crc_hi, b} == run_crc) parse_ph = PH_TAIL;
        else if (b == head1_reg) restart_frame();
        else clear_frame();
      end
      PH_TAIL: begin
        if (b == trailer_reg) begin
          if (frame_len == 0) begin
            frame_words.push_back('{cmd: frame_cmd, len: 6'd0, has_pay: 1'b0, data: 8'h00,
                                    idx: 6'd0, last: 1'b1});
          end else begin
            for (int k = 0; k < int'(frame_len); k++) begin
              frame_words.push_back('{cmd: frame_cmd, len: frame_len, has_pay: 1'b1,
                                      data: pay_buf[k], idx: 6'(k),
                                      last: (k + 1 == int'(frame_len))});
            end
          end
          clear_frame();
        end else if (b == head1_reg) begin
          restart_frame();
        end else begin
          clear_frame();
        end
      end
      default: clear_frame();
    endcase
  endfunction

  function automatic stim_row_t row(input byte_src_t s, input logic [7:0] v);
    return '{src: s, val: v, typed: 1'b0, word: '0};
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= REPORT_CAP)
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endfunction

  // Sends the queued rows in bursts with random gaps. CRC rows are resolved against the
  // model at send time, so they always reflect the bytes accepted so far.
  task automatic play_rows();
    stim_row_t  r;
    logic [7:0] v;
    int         gap;
    while (stim_rows.size() > 0) begin
      r = stim_rows.pop_front();
      case (r.src)
        B_CRC_HI:     v = run_crc[15:8];
        B_CRC_LO:     v = run_crc[7:0];
        B_CRC_HI_BAD: v = ~run_crc[15:8];
        default:      v = r.val;
      endcase
      if (burst_left == 0) begin
        gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        burst_left = $urandom_range(1, 16);
        if (gap > 0) begin
          rx_ch.valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      burst_left--;
      rx_ch.valid   <= 1'b1;
      rx_ch.rx_byte <= v;
      do @(posedge clk); while (!rx_ch.ready);
      parse_rx_byte(v);
      if (r.typed) pending_words.push_back(r.word);
      else foreach (frame_words[i]) pending_words.push_back(frame_words[i]);
      @(negedge clk);
    end
  endtask

  // Clean frames with random content in half of the cases; the rest are noise and broken frames.
  task automatic queue_random_frames(input int n_bytes, input bit long_frame);
    int shape;
    int len;
    while (stim_rows.size() < n_bytes) begin
      shape = long_frame ? 9 : $urandom_range(0, 9);
      if (long_frame) len = MAX_LEN;
      else if ($urandom_range(0, 9) == 0) len = $urandom_range(7, 24);
      else len = $urandom_range(0, 6);
      long_frame = 1'b0;
      case (shape)
        0: begin
          repeat ($urandom_range(1, 4)) stim_rows.push_back(row(B_LIT, 8'($urandom)));
        end
        1: begin
          stim_rows.push_back(row(B_LIT, head1_reg));
          stim_rows.push_back(row(B_LIT, 8'($urandom)));
        end
        2: begin
          stim_rows.push_back(row(B_LIT, head1_reg));
          stim_rows.push_back(row(B_LIT, head2_reg));
          stim_rows.push_back(row(B_LIT, 8'($urandom_range(MAX_LEN + 1, 255))));
        end
        default: begin
          // A repeated first header byte must restart the frame.
          if (shape == 3) stim_rows.push_back(row(B_LIT, head1_reg));
          stim_rows.push_back(row(B_LIT, head1_reg));
          stim_rows.push_back(row(B_LIT, head2_reg));
          stim_rows.push_back(row(B_LIT, 8'(len)));
          stim_rows.push_back(row(B_LIT, 8'($urandom)));
          repeat (len) stim_rows.push_back(row(B_LIT, 8'($urandom)));
          if (shape == 4) begin
            stim_rows.push_back(row(B_CRC_HI_BAD, 8'h00));
            stim_rows.push_back(row(B_LIT, $urandom_range(0, 1) ? head1_reg : 8'($urandom)));
          end else begin
            stim_rows.push_back(row(B_CRC_HI, 8'h00));
            stim_rows.push_back(row(B_CRC_LO, 8'h00));
            if (shape == 5)
              stim_rows.push_back(row(B_LIT, $urandom_range(0, 1) ? head1_reg : 8'($urandom)));
            else
              stim_rows.push_back(row(B_LIT, trailer_reg));
          end
        end
      endcase
    end
  endtask

  // Holds the sender off until every expected word has drained, plus a margin for
  // bytes that the block may still be working on.
  task automatic wait_quiet();
    rx_ch.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [7:0] val);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wdata     <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      CFG_HEAD1:   head1_reg = val;
      CFG_HEAD2:   head2_reg = val;
      CFG_TRAILER: trailer_reg = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic reconfigure(input logic [7:0] h1, input logic [7:0] h2, input logic [7:0] tl);
    wait_quiet();
    write_reg(CFG_HEAD1, h1);
    write_reg(CFG_HEAD2, h2);
    write_reg(CFG_TRAILER, tl);
    cfg_ch.valid <= 1'b0;
  endtask

  // The receiver switches between stall patterns.
  always @(negedge clk) begin
    if ((stall_tick % 48) == 0) stall_mode = $urandom_range(0, 3);
    stall_tick++;
    case (stall_mode)
      0:       res_ch.ready <= 1'b1;
      1:       res_ch.ready <= ($urandom_range(0, 3) != 0);
      2:       res_ch.ready <= ((stall_tick % 8) < 3);
      default: res_ch.ready <= ($urandom_range(0, 1) == 1);
    endcase
  end

  always @(posedge clk) begin : word_check
    frame_word_t got;
    frame_word_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got = '{cmd: res_ch.frame_cmd, len: res_ch.payload_len, has_pay: res_ch.has_payload,
              data: res_ch.data_byte, idx: res_ch.byte_index, last: res_ch.last};
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_CAP)
          $display("%0t: unexpected word, expected none, actual cmd 0x%0h data 0x%0h idx %0d",
                   $time, got.cmd, got.data, got.idx);
      end else begin
        want = pending_words.pop_front();
        check_field("frame_cmd", want.cmd, got.cmd);
        check_field("payload_len", want.len, got.len);
        check_field("has_payload", want.has_pay, got.has_pay);
        check_field("data_byte", want.data, got.data);
        check_field("byte_index", want.idx, got.idx);
        check_field("last", want.last, got.last);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    stim_row_t empty_tail;
    rst              = 1'b1;
    rx_ch.valid      = 1'b0;
    rx_ch.rx_byte    = 8'h00;
    cfg_ch.valid     = 1'b0;
    cfg_ch.reg_index = CFG_HEAD1;
    cfg_ch.wdata     = 8'h00;
    res_ch.ready     = 1'b0;
    mismatches       = 0;
    burst_left       = 0;
    stall_tick       = 0;
    stall_mode       = 0;
    head1_reg        = RST_HEAD1;
    head2_reg        = RST_HEAD2;
    trailer_reg      = RST_TRAILER;
    clear_frame();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // An empty-payload frame releases a single marked word with no data.
    empty_tail       = row(B_LIT, RST_TRAILER);
    empty_tail.typed = 1'b1;
    empty_tail.word  = '{cmd: 8'hC3, len: 6'd0, has_pay: 1'b0, data: 8'h00, idx: 6'd0,
                         last: 1'b1};
    stim_rows = '{
      // First header byte seen twice, then an empty-payload frame.
      row(B_LIT, 8'hA5), row(B_LIT, 8'hA5), row(B_LIT, 8'h5A), row(B_LIT, 8'h00),
      row(B_LIT, 8'hC3), row(B_CRC_HI, 8'h00), row(B_CRC_LO, 8'h00), empty_tail,
      // Length one past the buffer limit drops the frame.
      row(B_LIT, 8'hA5), row(B_LIT, 8'h5A), row(B_LIT, 8'h3A),
      // Bad CRC whose low byte is the first header byte starts a new frame.
      row(B_LIT, 8'hA5), row(B_LIT, 8'h5A), row(B_LIT, 8'h01), row(B_LIT, 8'h00),
      row(B_LIT, 8'hFF), row(B_CRC_HI_BAD, 8'h00), row(B_LIT, 8'hA5),
      // Wrong tail equal to the first header byte starts a new frame too.
      row(B_LIT, 8'h5A), row(B_LIT, 8'h00), row(B_LIT, 8'h7E), row(B_CRC_HI, 8'h00),
      row(B_CRC_LO, 8'h00), row(B_LIT, 8'hA5),
      row(B_LIT, 8'h5A), row(B_LIT, 8'h02), row(B_LIT, 8'hFF), row(B_LIT, 8'h00),
      row(B_LIT, 8'h80), row(B_CRC_HI, 8'h00), row(B_CRC_LO, 8'h00), row(B_LIT, 8'hFF)
    };
    play_rows();

    queue_random_frames(RAND_BYTES, 1'b0);
    play_rows();

    reconfigure(8'h00, 8'hFF, 8'h00);
    queue_random_frames(RAND_BYTES, 1'b0);
    play_rows();

    // One frame with the largest payload the buffer holds.
    reconfigure(8'hFF, 8'h00, 8'hFF);
    queue_random_frames(RAND_BYTES, 1'b0);
    queue_random_frames(stim_rows.size() + 1, 1'b1);
    play_rows();

    reconfigure(8'($urandom), 8'($urandom), 8'($urandom));
    queue_random_frames(RAND_BYTES, 1'b0);
    play_rows();

    wait_quiet();
    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
